FILE: src/nirpd_pkg.sv
// Package for the NEC infrared pulse decoder.
// Holds register indexes and reset values, position and status codes, and the
// structs shared by the configuration, core and top-level modules.
package nirpd_pkg;

    localparam int CFG_W       = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int TICK_W      = 8;
    localparam int POS_W       = 7;
    localparam int KEY_W       = 32;
    localparam int STAT_W      = 2;
    localparam int DEF_CODE_BITS = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_MARK_MIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TWO_MS_TICKS        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_MARK_MIN      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_THREE_MS_TICKS      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FOUR_MS_TICKS       = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FIVE_MS_TICKS       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_SPACE_THRESHOLD = 3'd6;

    // Register reset values.
    localparam logic [CFG_W-1:0] RST_HEADER_MARK_MIN     = 8'd145;
    localparam logic [CFG_W-1:0] RST_TWO_MS_TICKS        = 8'd32;
    localparam logic [CFG_W-1:0] RST_SHORT_MARK_MIN      = 8'd4;
    localparam logic [CFG_W-1:0] RST_THREE_MS_TICKS      = 8'd48;
    localparam logic [CFG_W-1:0] RST_FOUR_MS_TICKS       = 8'd64;
    localparam logic [CFG_W-1:0] RST_FIVE_MS_TICKS       = 8'd80;
    localparam logic [CFG_W-1:0] RST_BIT_SPACE_THRESHOLD = 8'd18;

    // Position counter codes; zero and up are data bit positions.
    localparam logic signed [POS_W-1:0] POS_ERROR     = -7'sd10;
    localparam logic signed [POS_W-1:0] POS_RPT_SPACE = -7'sd5;
    localparam logic signed [POS_W-1:0] POS_RPT_MARK  = -7'sd4;
    localparam logic signed [POS_W-1:0] POS_HEADER    = -7'sd2;
    localparam logic signed [POS_W-1:0] POS_HDR_DONE  = -7'sd1;
    localparam logic signed [POS_W-1:0] POS_ZERO      = 7'sd0;
    localparam logic signed [POS_W-1:0] POS_MAX       = 7'sd63;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_BUSY   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEWKEY = 2'd1;
    localparam logic [STAT_W-1:0] ST_REPEAT = 2'd2;
    localparam logic [STAT_W-1:0] ST_ERROR  = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] header_mark_min;
        logic [CFG_W-1:0] two_ms_ticks;
        logic [CFG_W-1:0] short_mark_min;
        logic [CFG_W-1:0] three_ms_ticks;
        logic [CFG_W-1:0] four_ms_ticks;
        logic [CFG_W-1:0] five_ms_ticks;
        logic [CFG_W-1:0] bit_space_threshold;
    } t_cfg;

    typedef struct packed {
        logic              forget_held_key;
        logic [KEY_W-1:0]  key_code;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

FILE: src/nirpd_cfg_regs.sv
// Configuration register file of the NEC infrared pulse decoder.
// Seven byte-wide timing registers behind a plain write port; uses nirpd_pkg.
module nirpd_cfg_regs
    import nirpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mark_min     <= RST_HEADER_MARK_MIN;
            r_cfg.two_ms_ticks        <= RST_TWO_MS_TICKS;
            r_cfg.short_mark_min      <= RST_SHORT_MARK_MIN;
            r_cfg.three_ms_ticks      <= RST_THREE_MS_TICKS;
            r_cfg.four_ms_ticks       <= RST_FOUR_MS_TICKS;
            r_cfg.five_ms_ticks       <= RST_FIVE_MS_TICKS;
            r_cfg.bit_space_threshold <= RST_BIT_SPACE_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_HEADER_MARK_MIN:     r_cfg.header_mark_min     <= i_cfg_wdata;
                REG_TWO_MS_TICKS:        r_cfg.two_ms_ticks        <= i_cfg_wdata;
                REG_SHORT_MARK_MIN:      r_cfg.short_mark_min      <= i_cfg_wdata;
                REG_THREE_MS_TICKS:      r_cfg.three_ms_ticks      <= i_cfg_wdata;
                REG_FOUR_MS_TICKS:       r_cfg.four_ms_ticks       <= i_cfg_wdata;
                REG_FIVE_MS_TICKS:       r_cfg.five_ms_ticks       <= i_cfg_wdata;
                REG_BIT_SPACE_THRESHOLD: r_cfg.bit_space_threshold <= i_cfg_wdata;
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/nirpd_core.sv
// Decode core of the NEC infrared pulse decoder: mark classing, space handling,
// position counter and received code register; uses nirpd_pkg.
module nirpd_core
    import nirpd_pkg::*;
#(
    parameter int CODE_BITS = DEF_CODE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [TICK_W-1:0] i_mark,
    input  logic [TICK_W-1:0] i_space,
    input  t_cfg              i_cfg,
    output t_result           o_result
);

    localparam int IDX_W = $clog2(CODE_BITS);
    localparam logic signed [POS_W-1:0] LAST_POS = POS_W'(CODE_BITS - 1);

    logic signed [POS_W-1:0] r_pos;
    logic signed [POS_W-1:0] n_pos;
    logic [CODE_BITS-1:0]    r_code;
    logic [CODE_BITS-1:0]    n_code;

    logic                    hdr_mark;
    logic                    short_mark;
    logic                    long_space;
    logic                    bit_one;
    logic                    store;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] pos_mark;
    logic [TICK_W:0]         hdr_limit;
    logic [STAT_W-1:0]       status;
    logic                    forget;

    always_comb begin
        hdr_limit  = {1'b0, i_cfg.header_mark_min} + {1'b0, i_cfg.two_ms_ticks};
        hdr_mark   = (i_mark >= i_cfg.header_mark_min) && ({1'b0, i_mark} <= hdr_limit);
        short_mark = (i_mark >= i_cfg.short_mark_min)
                     && (i_mark <= (i_cfg.header_mark_min >> 3));
        long_space = i_space >= i_cfg.three_ms_ticks;
        bit_one    = i_space >= i_cfg.bit_space_threshold;

        if (hdr_mark) begin
            pos_mark = POS_HEADER;
        end else if (short_mark) begin
            pos_mark = (r_pos < POS_MAX) ? r_pos + 7'sd1 : r_pos;
        end else begin
            pos_mark = POS_ERROR;
        end

        store  = 1'b0;
        status = ST_BUSY;
        forget = 1'b0;
        n_pos  = pos_mark;
        idx    = pos_mark[IDX_W-1:0];

        if (!long_space && pos_mark >= POS_ZERO) begin
            // A bit beyond the code register is a frame error.
            if (pos_mark > LAST_POS) begin
                n_pos = POS_ERROR;
            end else begin
                store = 1'b1;
            end
        end else if (long_space && pos_mark > POS_ZERO) begin
            status = ST_NEWKEY;
        end else if (pos_mark == POS_HEADER && i_space >= i_cfg.two_ms_ticks
                     && i_space <= i_cfg.three_ms_ticks) begin
            n_pos = POS_RPT_SPACE;
        end else if (long_space && pos_mark == POS_RPT_MARK) begin
            status = ST_REPEAT;
            n_pos  = pos_mark + 7'sd1;
        end else if (pos_mark == POS_HEADER && i_space >= i_cfg.four_ms_ticks
                     && i_space <= i_cfg.five_ms_ticks) begin
            n_pos  = POS_HDR_DONE;
            forget = 1'b1;
        end else begin
            n_pos = POS_ERROR;
        end

        if (n_pos <= POS_ERROR) begin
            status = ST_ERROR;
            forget = 1'b1;
        end

        n_code = r_code;
        for (int i = 0; i < CODE_BITS; i++) begin
            if (store && idx == IDX_W'(i)) begin
                n_code[i] = bit_one;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_ZERO;
            r_code <= '0;
        end else if (i_adv) begin
            r_pos  <= n_pos;
            r_code <= n_code;
        end
    end

    assign o_result.status          = status;
    assign o_result.key_code        = KEY_W'(n_code);
    assign o_result.forget_held_key = forget;

endmodule

FILE: src/nec_ir_pulse_decoder.sv
// NEC infrared pulse decoder, top level: input beat register, decode core,
// result register and configuration registers; uses nirpd_pkg.
//
// Each input beat carries one mark width and the following space width in
// timer ticks and yields exactly one result beat with the status, the code
// register contents after the update and the forget-held-key flag. A beat
// goes through the input register, then the decode logic into the result
// register. A new beat is taken every cycle unless the result register is
// full and not drained; the single decode pass also updates the position
// counter and code register. The user must write configuration registers
// through the plain write port only while idle; the block does not enforce it.
module nec_ir_pulse_decoder
    import nirpd_pkg::*;
#(
    parameter int CODE_BITS = DEF_CODE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // [7:0] mark_ticks, [15:8] space_ticks
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,  // [1:0] status, [33:2] key_code,
                                                 // [34] forget_held_key, [39:35] zero
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    t_cfg              cfg;
    t_result           result;
    logic              adv;
    logic              r_in_valid;
    logic [TICK_W-1:0] r_mark;
    logic [TICK_W-1:0] r_space;
    logic              r_out_valid;
    t_result           r_out;

    nirpd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    nirpd_core #(
        .CODE_BITS (CODE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_mark   (r_mark),
        .i_space  (r_space),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // The held beat moves on whenever the result register is empty or drained.
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_mark  <= s_axis_tdata[7:0];
            r_space <= s_axis_tdata[15:8];
        end
        if (adv) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out};

endmodule

FILE: src/nirpd_checker.sv
// Port-level checker for the NEC infrared pulse decoder, bound to the top level.
// Depends on nirpd_pkg for the status codes.
module nirpd_checker
    import nirpd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // Every accepted beat shows up on the result side once it has passed the input and result registers.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted beat produced no result");

    // An error always drops the held key.
    a_err_forget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_ERROR |-> m_axis_tdata[34])
        else $error("error result without forget flag");

    // A completed key or a repeat never drops the held key.
    a_key_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == ST_NEWKEY || m_axis_tdata[1:0] == ST_REPEAT)
        |-> !m_axis_tdata[34])
        else $error("key result with forget flag");

endmodule

bind nec_ir_pulse_decoder nirpd_checker u_nirpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
